FILE: hdl/mbh_pkg.sv
// Shared types and constants of the monotone bicubic Hermite interpolator.
package mbh_pkg;

   localparam int NUM_LANES = 4;
   localparam int NUM_TERMS = 4;
   localparam int TERM_W    = $clog2(NUM_TERMS);

   typedef enum logic [1:0] {
      ACT_LOAD_X      = 2'd0,
      ACT_LOAD_Z      = 2'd1,
      ACT_LOAD_CORNER = 2'd2,
      ACT_COMPUTE     = 2'd3
   } mbh_action_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_XBLEND = 3'b010,
      ST_ZBLEND = 3'b100
   } mbh_state_type;

endpackage

FILE: hdl/mbh_mac.sv
// Four-term Hermite blend unit: serial half-width partial products, wide accumulate, saturate.
module mbh_mac
   import mbh_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   output logic [TERM_W-1:0]             term,
   input  logic signed [VALUE_WIDTH-1:0] opnd_a,
   input  logic signed [VALUE_WIDTH-1:0] opnd_b,
   output logic                          done,
   output logic signed [VALUE_WIDTH-1:0] blend
);

   localparam int H     = (VALUE_WIDTH + 1) / 2;
   localparam int HI_W  = VALUE_WIDTH - H;
   localparam int PW    = 2 * H + 2;
   localparam int ACC_W = 2 * VALUE_WIDTH + 2;
   localparam int CNT_W = TERM_W + 2;
   localparam logic [CNT_W-1:0] CNT_LAST = '1;
   localparam logic signed [VALUE_WIDTH-1:0] MAX_V = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] MIN_V = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    run_ff, run_in;
   logic                    pvld_ff, plast_ff, fin_ff, done_ff;
   logic [1:0]              psh_ff, psh_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [VALUE_WIDTH-1:0] blend_ff, blend_in;

   logic signed [HI_W-1:0]  a_hi, b_hi;
   logic signed [H:0]       mul_a, mul_b;
   logic signed [ACC_W-1:0] addend, shifted;
   logic [ACC_W-VALUE_WIDTH:0] top_bits;

   assign term = cnt_ff[CNT_W-1:2];
   assign a_hi = opnd_a[VALUE_WIDTH-1:H];
   assign b_hi = opnd_b[VALUE_WIDTH-1:H];

   // cnt[1] picks the half of a, cnt[0] the half of b; low halves are unsigned
   always_comb begin
      mul_a   = cnt_ff[1] ? (H+1)'(a_hi) : {1'b0, opnd_a[H-1:0]};
      mul_b   = cnt_ff[0] ? (H+1)'(b_hi) : {1'b0, opnd_b[H-1:0]};
      prod_in = PW'(mul_a) * PW'(mul_b);
      psh_in  = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
   end

   always_comb begin
      case (psh_ff)
         2'd0:    addend = ACC_W'(prod_ff);
         2'd1:    addend = ACC_W'(prod_ff) <<< H;
         2'd2:    addend = ACC_W'(prod_ff) <<< (2 * H);
         default: addend = '0;
      endcase
   end

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in = 1'b0;
         end
      end
      acc_in = acc_ff;
      if (go) begin
         acc_in = '0;
      end else if (pvld_ff) begin
         acc_in = acc_ff + addend;
      end
   end

   // drop the fraction bits, then saturate to the signed value range
   always_comb begin
      shifted  = acc_ff >>> FRAC_BITS;
      top_bits = shifted[ACC_W-1:VALUE_WIDTH-1];
      if ((&top_bits) || !(|top_bits)) begin
         blend_in = shifted[VALUE_WIDTH-1:0];
      end else begin
         blend_in = shifted[ACC_W-1] ? MIN_V : MAX_V;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         cnt_ff   <= '0;
         pvld_ff  <= 1'b0;
         plast_ff <= 1'b0;
         fin_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         cnt_ff   <= cnt_in;
         pvld_ff  <= run_ff;
         plast_ff <= run_ff && (cnt_ff == CNT_LAST);
         fin_ff   <= plast_ff;
         done_ff  <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      psh_ff  <= psh_in;
      acc_ff  <= acc_in;
      if (fin_ff) begin
         blend_ff <= blend_in;
      end
   end

   assign done  = done_ff;
   assign blend = blend_ff;

endmodule

FILE: hdl/mbh_merge.sv
// Merge stage: Z-direction blend of the four lane results, then clamp to the corner range.
module mbh_merge
   import mbh_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic signed [VALUE_WIDTH-1:0] lane_res [NUM_LANES],
   input  logic signed [VALUE_WIDTH-1:0] wz       [NUM_TERMS],
   input  logic signed [VALUE_WIDTH-1:0] corner_f [NUM_LANES],
   output logic                          done,
   output logic signed [VALUE_WIDTH-1:0] result
);

   logic [TERM_W-1:0]             term;
   logic                          mac_done;
   logic signed [VALUE_WIDTH-1:0] mac_blend;
   logic signed [VALUE_WIDTH-1:0] lo_in, hi_in, lo01, lo23, hi01, hi23;
   logic signed [VALUE_WIDTH-1:0] lo_ff, hi_ff;
   logic signed [VALUE_WIDTH-1:0] result_ff, result_in;
   logic                          done_ff;

   mbh_mac #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .term   (term),
      .opnd_a (lane_res[term]),
      .opnd_b (wz[term]),
      .done   (mac_done),
      .blend  (mac_blend)
   );

   always_comb begin
      lo01  = (corner_f[1] < corner_f[0]) ? corner_f[1] : corner_f[0];
      lo23  = (corner_f[3] < corner_f[2]) ? corner_f[3] : corner_f[2];
      hi01  = (corner_f[0] < corner_f[1]) ? corner_f[1] : corner_f[0];
      hi23  = (corner_f[2] < corner_f[3]) ? corner_f[3] : corner_f[2];
      lo_in = (lo23 < lo01) ? lo23 : lo01;
      hi_in = (hi01 < hi23) ? hi23 : hi01;
   end

   always_comb begin
      if (hi_ff < mac_blend) begin
         result_in = hi_ff;
      end else if (mac_blend < lo_ff) begin
         result_in = lo_ff;
      end else begin
         result_in = mac_blend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= mac_done;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (mac_done) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

FILE: hdl/monotone_bicubic_hermite_interp.sv
// Top level of the monotone bicubic Hermite interpolator: stores, four X lanes, merge stage.
//
//   channel   ports                                   beat taken when
//   --------  --------------------------------------  -----------------------------
//   request   req_action req_slot req_value_a..d      start high and busy low
//   response  rsp_result                               rsp_valid high (one cycle)
//
// A load beat (X weights, Z weights, one corner) writes its store and busy stays low.
// A compute beat: four X blends side by side (16 serial half-width partial products per
// lane multiplier, accumulate, saturate), a handoff of the lane results, the Z blend in
// the merge unit, then the clamp; rsp_valid rises with the registered clamp result and
// busy drops in the cycle after that.
// Reset clears the sequencer and the unit counters and done strobes only; stores hold garbage until loaded.
// The receiver cannot stall, so the result leaves on its single strobe cycle.
module monotone_bicubic_hermite_interp
   import mbh_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [1:0]         req_slot,
   input  logic signed [31:0] req_value_a,
   input  logic signed [31:0] req_value_b,
   input  logic signed [31:0] req_value_c,
   input  logic signed [31:0] req_value_d,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result
);

   mbh_state_type state_ff, state_in;

   logic                          accept;
   logic                          lane_go;
   logic [NUM_LANES-1:0]          lane_done;
   logic signed [VALUE_WIDTH-1:0] lane_res [NUM_LANES];
   logic signed [VALUE_WIDTH-1:0] in_val   [NUM_TERMS];
   logic signed [VALUE_WIDTH-1:0] wx_ff    [NUM_TERMS];
   logic signed [VALUE_WIDTH-1:0] wz_ff    [NUM_TERMS];
   logic signed [VALUE_WIDTH-1:0] corner_ff [NUM_LANES][NUM_TERMS];
   logic signed [VALUE_WIDTH-1:0] corner_f [NUM_LANES];
   logic signed [VALUE_WIDTH-1:0] merge_result;
   logic                          merge_done;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // wrap the 32-bit fields to the working width
   assign in_val[0] = VALUE_WIDTH'(req_value_a);
   assign in_val[1] = VALUE_WIDTH'(req_value_b);
   assign in_val[2] = VALUE_WIDTH'(req_value_c);
   assign in_val[3] = VALUE_WIDTH'(req_value_d);

   assign lane_go = accept && (mbh_action_type'(req_action) == ACT_COMPUTE);

   // sequencer: idle, X lanes running, merge running
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (lane_go) begin
               state_in = ST_XBLEND;
            end
         end
         ST_XBLEND: begin
            if (&lane_done) begin
               state_in = ST_ZBLEND;
            end
         end
         ST_ZBLEND: begin
            if (merge_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // load beats write the weight and corner stores; compute leaves them alone
   always_ff @(posedge clock) begin
      if (accept) begin
         case (mbh_action_type'(req_action))
            ACT_LOAD_X: begin
               wx_ff <= in_val;
            end
            ACT_LOAD_Z: begin
               wz_ff <= in_val;
            end
            ACT_LOAD_CORNER: begin
               corner_ff[req_slot] <= in_val;
            end
            default: begin
            end
         endcase
      end
   end

   // Lane bit 0 picks the corner row (z or z+1), lane bit 1 picks value/fx versus
   // fz/fxz; term bit 0 steps x, term bit 1 steps to the derivative entry.
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      localparam logic [1:0] LID = 2'(l);
      logic [TERM_W-1:0]             term;
      logic signed [VALUE_WIDTH-1:0] lane_a;

      assign lane_a      = corner_ff[{LID[0], term[0]}][{LID[1], term[1]}];
      assign corner_f[l] = corner_ff[l][0];

      mbh_mac #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .FRAC_BITS   (FRAC_BITS)
      ) u_mac (
         .clock  (clock),
         .reset  (reset),
         .go     (lane_go),
         .term   (term),
         .opnd_a (lane_a),
         .opnd_b (wx_ff[term]),
         .done   (lane_done[l]),
         .blend  (lane_res[l])
      );
   end

   // all lanes finish together; hand their results to the Z blend
   mbh_merge #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .go       (&lane_done),
      .lane_res (lane_res),
      .wz       (wz_ff),
      .corner_f (corner_f),
      .done     (merge_done),
      .result   (merge_result)
   );

   assign rsp_valid  = merge_done;
   assign rsp_result = 32'(merge_result);

endmodule
